>>> design/cpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types, constants and the CRC-8 helper for the packet framer.
// ----------------------------------------------------------------------------
package cpf_pkg;

    // Input action codes.
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    // Framing constants.
    localparam logic [7:0] PREAMBLE_HI = 8'hAA;
    localparam logic [7:0] PREAMBLE_LO = 8'h55;
    localparam logic [7:0] CRC_POLY    = 8'h07;

    // Job queue sizing.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Output step counter: a start job emits up to five bytes.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_PRE_HI = 3'd0;
    localparam logic [STEP_W-1:0] STEP_PRE_LO = 3'd1;
    localparam logic [STEP_W-1:0] STEP_TYPE   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LEN    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_CRC    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DATA   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DCRC   = 3'd1;

    typedef enum logic {
        JOB_START   = 1'b0,
        JOB_PAYLOAD = 1'b1
    } job_kind_t;

    // One classified transaction, waiting to be serialized.
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] b0;       // type byte or payload byte
        logic [7:0] b1;       // length byte (start only)
        logic [7:0] crc;      // CRC byte, valid when has_crc is set
        logic       has_crc;  // job closes the packet
    } job_t;

    // CRC-8, MSB first, no reflection, no final XOR.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage
`default_nettype wire

>>> design/crc8_packet_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_packet_framer
// Packet framer producing preamble, header, payload and CRC-8 byte stream.
// ----------------------------------------------------------------------------
// A start transaction yields 0xAA, 0x55, type, length and, when the length is
// zero, the CRC-8 byte (poly 0x07, init 0); each payload transaction yields the
// echoed byte and, on the last counted byte, the CRC byte with packet_end set.
// run_last marks the final byte caused by each input transaction, and payload
// bytes with no open packet are dropped without output. Output runs at one byte
// per cycle while out_ready is high; a payload transaction yields one or two
// bytes and a start four or five. Input is taken every cycle while the
// four-entry job queue has room, so it keeps accepting while output is
// stalled until the queue fills.
// ----------------------------------------------------------------------------
module crc8_packet_framer
    import cpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       action,
    input  wire logic [7:0] pkt_type,
    input  wire logic [7:0] pkt_len,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            packet_end,
    output logic            run_last
);

    job_t push_job;
    job_t head_job;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    // Front end: classification and CRC tracking.
    cpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .pkt_type  (pkt_type),
        .pkt_len   (pkt_len),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    // Job queue decoupling the two sides.
    cpf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    // Back end: byte serializer.
    cpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .packet_end (packet_end),
        .run_last   (run_last)
    );

endmodule
`default_nettype wire

>>> design/cpf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_front
// Accepts input transactions, tracks the open packet and its CRC, and hands
// one classified job per transaction, but for a dropped payload byte, to the job queue.
// ----------------------------------------------------------------------------
module cpf_front
    import cpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       action,
    input  wire logic [7:0] pkt_type,
    input  wire logic [7:0] pkt_len,
    input  wire logic [7:0] data_byte,
    input  wire logic       q_full,
    output logic            q_push,
    output job_t            q_job
);

    logic [7:0] crc_acc_reg, crc_acc_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       packet_open_reg, packet_open_next;

    logic       accept;
    logic [7:0] crc_type;
    logic [7:0] crc_start;
    logic [7:0] crc_data;
    logic [7:0] left_dec;

    // CRC candidates for both kinds of transaction.
    assign crc_type  = crc8_fold(8'h00, pkt_type);
    assign crc_start = crc8_fold(crc_type, pkt_len);
    assign crc_data  = crc8_fold(crc_acc_reg, data_byte);
    assign left_dec  = bytes_left_reg - 8'd1;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify the transaction and update the packet state.
    always_comb begin
        crc_acc_next     = crc_acc_reg;
        bytes_left_next  = bytes_left_reg;
        packet_open_next = packet_open_reg;
        q_push           = 1'b0;
        q_job.kind       = JOB_START;
        q_job.b0         = pkt_type;
        q_job.b1         = pkt_len;
        q_job.crc        = crc_start;
        q_job.has_crc    = 1'b0;
        if (accept) begin
            if (action == ACT_START) begin
                q_push = 1'b1;
                if (pkt_len == 8'd0) begin
                    q_job.has_crc    = 1'b1;
                    crc_acc_next     = 8'h00;
                    bytes_left_next  = 8'd0;
                    packet_open_next = 1'b0;
                end else begin
                    crc_acc_next     = crc_start;
                    bytes_left_next  = pkt_len;
                    packet_open_next = 1'b1;
                end
            end else if (packet_open_reg) begin
                // A payload byte with no open packet is dropped silently.
                q_push          = 1'b1;
                q_job.kind      = JOB_PAYLOAD;
                q_job.b0        = data_byte;
                q_job.crc       = crc_data;
                bytes_left_next = left_dec;
                if (left_dec == 8'd0) begin
                    q_job.has_crc    = 1'b1;
                    crc_acc_next     = 8'h00;
                    packet_open_next = 1'b0;
                end else begin
                    crc_acc_next = crc_data;
                end
            end
        end
    end

    // Packet state registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            crc_acc_reg     <= 8'h00;
            bytes_left_reg  <= 8'd0;
            packet_open_reg <= 1'b0;
        end else begin
            crc_acc_reg     <= crc_acc_next;
            bytes_left_reg  <= bytes_left_next;
            packet_open_reg <= packet_open_next;
        end
    end

endmodule
`default_nettype wire

>>> design/cpf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_queue
// Small FIFO of classified jobs between the front and the back end.
// ----------------------------------------------------------------------------
module cpf_queue
    import cpf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      head_job,
    output logic      empty
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop && !empty)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if ((push && !full) && !(pop && !empty))
            count_next = count_reg + 1'b1;
        else if (!(push && !full) && (pop && !empty))
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge clk) begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

>>> design/cpf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_back
// Serializes the job at the head of the queue into framed output bytes,
// one output transaction per step.
// ----------------------------------------------------------------------------
module cpf_back
    import cpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  job_t            head_job,
    input  wire logic       q_empty,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            packet_end,
    output logic            run_last
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] last_step;
    logic              out_fire;

    assign out_valid = !q_empty;
    assign out_fire  = out_valid && out_ready;

    // Last step and byte selection for the head job.
    always_comb begin
        out_byte   = head_job.b0;
        packet_end = 1'b0;
        if (head_job.kind == JOB_START) begin
            last_step = head_job.has_crc ? STEP_CRC : STEP_LEN;
            case (step_reg)
                STEP_PRE_HI: out_byte = PREAMBLE_HI;
                STEP_PRE_LO: out_byte = PREAMBLE_LO;
                STEP_TYPE:   out_byte = head_job.b0;
                STEP_LEN:    out_byte = head_job.b1;
                default:
                begin
                    out_byte   = head_job.crc;
                    packet_end = 1'b1;
                end
            endcase
        end else begin
            last_step = head_job.has_crc ? STEP_DCRC : STEP_DATA;
            if (step_reg == STEP_DCRC) begin
                out_byte   = head_job.crc;
                packet_end = 1'b1;
            end
        end
    end

    assign run_last = (step_reg == last_step);
    assign q_pop    = out_fire && run_last;

    // Step counter advances on every output transaction.
    always_comb begin
        step_next = step_reg;
        if (out_fire)
            step_next = run_last ? '0 : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

endmodule
`default_nettype wire

>>> tb/sv/crc8_packet_framer_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_packet_framer_tb
// Self-checking testbench for the CRC-8 packet framer.
// ----------------------------------------------------------------------------
// A short table of directed transactions covers the field extremes, zero
// length packets, dropped payload bytes and abandoned packets. Random packets
// follow: mostly complete ones with random content, plus broken packets and
// stray payload bytes. Every accepted input transaction runs through a local
// framing predictor, and every output transaction is compared with the oldest
// predicted byte. Both channels idle at random in the first two of three random phases.
// ----------------------------------------------------------------------------
module crc8_packet_framer_tb;
    import cpf_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 133;
    localparam int NUM_DIRECTED  = 22;

    // One byte of the framed output stream.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       run_last;
    } frame_byte_t;

    // One directed transaction. Where known is set, the framed bytes are typed
    // in here; the last one carries packet_end when ends_crc is set.
    typedef struct packed {
        logic            act;
        logic [7:0]      typ;
        logic [7:0]      len;
        logic [7:0]      dat;
        logic            known;
        logic [2:0]      n_out;
        logic [0:4][7:0] bytes;
        logic            ends_crc;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       action;
    logic [7:0] pkt_type;
    logic [7:0] pkt_len;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_last;

    // Predictor state.
    logic [7:0] crc_run;
    logic [7:0] bytes_due;
    logic       pkt_open;

    frame_byte_t framed_bytes_q[$];
    int          error_cnt;
    int          tx_idle_pct;
    int          rx_stall_pct;

    dir_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        // Payload right after reset is dropped.
        '{ACT_PAYLOAD, 8'h00, 8'h00, 8'hFF, 1'b1, 3'd0, 40'h0, 1'b0},
        // Zero length with zero header: the CRC is zero too.
        '{ACT_START, 8'h00, 8'h00, 8'h00, 1'b1, 3'd5,
            {8'hAA, 8'h55, 8'h00, 8'h00, 8'h00}, 1'b1},
        '{ACT_START, 8'hFF, 8'h01, 8'h00, 1'b1, 3'd4,
            {8'hAA, 8'h55, 8'hFF, 8'h01, 8'h00}, 1'b0},
        '{ACT_PAYLOAD, 8'h00, 8'h00, 8'hFF, 1'b0, 3'd0, 40'h0, 1'b0},
        // The packet has closed, so this byte is dropped.
        '{ACT_PAYLOAD, 8'hFF, 8'hFF, 8'h5A, 1'b1, 3'd0, 40'h0, 1'b0},
        '{ACT_START, 8'hA5, 8'hFF, 8'h00, 1'b1, 3'd4,
            {8'hAA, 8'h55, 8'hA5, 8'hFF, 8'h00}, 1'b0},
        '{ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0},
        '{ACT_PAYLOAD, 8'h00, 8'h00, 8'h80, 1'b0, 3'd0, 40'h0, 1'b0},
        '{ACT_PAYLOAD, 8'h00, 8'h00, 8'h7F, 1'b0, 3'd0, 40'h0, 1'b0},
        // A new start abandons the long packet without a CRC byte.
        '{ACT_START, 8'h5A, 8'h02, 8'hFF, 1'b1, 3'd4,
            {8'hAA, 8'h55, 8'h5A, 8'h02, 8'h00}, 1'b0},
        '{ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0},
        '{ACT_PAYLOAD, 8'h00, 8'h00, 8'hFF, 1'b0, 3'd0, 40'h0, 1'b0},
        '{ACT_START, 8'h00, 8'h01, 8'h00, 1'b1, 3'd4,
            {8'hAA, 8'h55, 8'h00, 8'h01, 8'h00}, 1'b0},
        '{ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0},
        // data_byte is ignored on a start.
        '{ACT_START, 8'hFF, 8'hFF, 8'hAB, 1'b1, 3'd4,
            {8'hAA, 8'h55, 8'hFF, 8'hFF, 8'h00}, 1'b0},
        '{ACT_START, 8'h80, 8'h00, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0},
        '{ACT_START, 8'h01, 8'h00, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0},
        '{ACT_PAYLOAD, 8'h00, 8'h00, 8'h12, 1'b1, 3'd0, 40'h0, 1'b0},
        '{ACT_START, 8'h00, 8'h03, 8'h00, 1'b1, 3'd4,
            {8'hAA, 8'h55, 8'h00, 8'h03, 8'h00}, 1'b0},
        // Type and length are ignored on payload transactions.
        '{ACT_PAYLOAD, 8'hFF, 8'hFF, 8'h01, 1'b0, 3'd0, 40'h0, 1'b0},
        '{ACT_PAYLOAD, 8'hFF, 8'hFF, 8'h02, 1'b0, 3'd0, 40'h0, 1'b0},
        '{ACT_PAYLOAD, 8'hFF, 8'hFF, 8'h03, 1'b0, 3'd0, 40'h0, 1'b0}
    };

    crc8_packet_framer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .pkt_type   (pkt_type),
        .pkt_len    (pkt_len),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .packet_end (packet_end),
        .run_last   (run_last)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // CRC-8 over one byte, one data bit at a time, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] dat);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ dat[i];
            c  = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return c;
    endfunction

    // Advance the predicted framer by one input transaction and, if asked,
    // queue the bytes it produces.
    function automatic void frame_item(input logic act, input logic [7:0] typ,
                                       input logic [7:0] len, input logic [7:0] dat,
                                       input bit push);
        frame_byte_t produced[$];
        if (act == ACT_START)
        begin
            produced.push_back('{PREAMBLE_HI, 1'b0, 1'b0});
            produced.push_back('{PREAMBLE_LO, 1'b0, 1'b0});
            produced.push_back('{typ, 1'b0, 1'b0});
            produced.push_back('{len, 1'b0, 1'b0});
            crc_run = crc8_step(crc8_step(8'h00, typ), len);
            if (len == 8'h00)
            begin
                produced.push_back('{crc_run, 1'b1, 1'b0});
                crc_run   = 8'h00;
                bytes_due = 8'h00;
                pkt_open  = 1'b0;
            end
            else
            begin
                bytes_due = len;
                pkt_open  = 1'b1;
            end
        end
        else if (pkt_open)
        begin
            produced.push_back('{dat, 1'b0, 1'b0});
            crc_run   = crc8_step(crc_run, dat);
            bytes_due = bytes_due - 8'd1;
            if (bytes_due == 8'h00)
            begin
                produced.push_back('{crc_run, 1'b1, 1'b0});
                crc_run  = 8'h00;
                pkt_open = 1'b0;
            end
        end
        if (produced.size() > 0)
            produced[produced.size()-1].run_last = 1'b1;
        if (push)
            foreach (produced[i])
                framed_bytes_q.push_back(produced[i]);
    endfunction

    task automatic note_error(input string msg);
        error_cnt++;
        if (error_cnt <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    // Present one input transaction, wait for it to be taken, then predict.
    task automatic offer_item(input logic act, input logic [7:0] typ,
                              input logic [7:0] len, input logic [7:0] dat,
                              input bit push);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        pkt_type  <= typ;
        pkt_len   <= len;
        data_byte <= dat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frame_item(act, typ, len, dat, push);
    endtask

    task automatic offer_payload();
        offer_item(ACT_PAYLOAD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 1'b1);
    endtask

    // Random packets: mostly complete short ones, some longer, some with a
    // fully random length that are usually cut short, and stray payload bytes.
    task automatic run_random(input int items);
        int         sent;
        int         pick;
        int         n_pay;
        logic [7:0] len;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(99);
            if (pick < 6 && !pkt_open)
            begin
                // Dropped by the block, so not counted.
                offer_payload();
            end
            else
            begin
                if (pick < 16)
                    len = 8'($urandom_range(255));
                else if (pick < 28)
                    len = 8'($urandom_range(32, 7));
                else
                    len = 8'($urandom_range(6));
                offer_item(ACT_START, 8'($urandom_range(255)), len,
                           8'($urandom_range(255)), 1'b1);
                sent++;
                n_pay = len;
                if (len > 8'd32)
                    n_pay = $urandom_range(8);
                else if ($urandom_range(99) < 10)
                    n_pay = $urandom_range(int'(len));
                for (int k = 0; k < n_pay; k++)
                begin
                    offer_payload();
                    sent++;
                end
            end
        end
    endtask

    // Output side: random stalls and the byte-by-byte check.
    initial
    begin
        frame_byte_t want;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (framed_bytes_q.size() == 0)
                begin
                    note_error($sformatf("byte %02h end %0b last %0b with nothing expected",
                                         out_byte, packet_end, run_last));
                end
                else
                begin
                    want = framed_bytes_q.pop_front();
                    if (out_byte !== want.out_byte || packet_end !== want.packet_end ||
                        run_last !== want.run_last)
                        note_error($sformatf(
                            "expected byte %02h end %0b last %0b, got byte %02h end %0b last %0b",
                            want.out_byte, want.packet_end, want.run_last,
                            out_byte, packet_end, run_last));
                end
            end
            if (rst_n)
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: too many cycles without any transaction ends the run.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("crc8_packet_framer_tb failed");
                $finish;
            end
        end
    end

    // Main sequence.
    initial
    begin
        dir_row_t row;
        error_cnt    = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        crc_run      = 8'h00;
        bytes_due    = 8'h00;
        pkt_open     = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= ACT_START;
        pkt_type     <= 8'h00;
        pkt_len      <= 8'h00;
        data_byte    <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling.
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            row = directed_rows[r];
            offer_item(row.act, row.typ, row.len, row.dat, !row.known);
            if (row.known)
                for (int i = 0; i < int'(row.n_out); i++)
                    framed_bytes_q.push_back('{row.bytes[i],
                                               row.ends_crc && (i == int'(row.n_out) - 1),
                                               i == int'(row.n_out) - 1});
        end

        // Random phases with different idling on each side.
        tx_idle_pct  = 37;
        rx_stall_pct = 60;
        run_random(RANDOM_ITEMS);
        tx_idle_pct  = 60;
        rx_stall_pct = 37;
        run_random(RANDOM_ITEMS);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random(RANDOM_ITEMS);
        in_valid <= 1'b0;

        // Drain, then keep watching for anything unexpected.
        while (framed_bytes_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_cnt == 0 && framed_bytes_q.size() == 0)
            $display("crc8_packet_framer_tb passed");
        else
            $display("crc8_packet_framer_tb failed");
        $finish;
    end

endmodule
`default_nettype wire
